/* hw/rtl/mreg_pkg.sv */
// Shared widths, codes and types of the mouse report event generator.
`default_nettype none

package mreg_pkg;

    localparam int DEFAULT_NUM_DEVICES = 4;

    localparam int DEV_W  = 2;
    localparam int POS_W  = 15;
    localparam int MOT_W  = 16;
    localparam int FLAG_W = 16;
    localparam int MOD_W  = 4;
    localparam int TOG_W  = 3;
    localparam int ACT_W  = 3;
    localparam int BTN_W  = 2;
    localparam int HELD_W = 3;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = DEV_W + ACT_W;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 2'd3;
    localparam logic [POS_W-1:0] X_MIN_RESET = 15'd0;
    localparam logic [POS_W-1:0] X_MAX_RESET = 15'd1920;
    localparam logic [POS_W-1:0] Y_MIN_RESET = 15'd0;
    localparam logic [POS_W-1:0] Y_MAX_RESET = 15'd1080;

    localparam logic [ACT_W-1:0] ACT_MOVE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DRAG    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PRESS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_WHEEL   = 3'd4;

    localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_LEFT   = 2'd1;
    localparam logic [BTN_W-1:0] BTN_MIDDLE = 2'd2;
    localparam logic [BTN_W-1:0] BTN_RIGHT  = 2'd3;

    // Buttons in event order: left, middle, right; held mask bit b is button b.
    localparam int NUM_BUTTONS = 3;
    localparam int DOWN_BIT [NUM_BUTTONS] = '{0, 4, 2};
    localparam int UP_BIT [NUM_BUTTONS] = '{1, 5, 3};
    localparam logic [BTN_W-1:0] BTN_OF [NUM_BUTTONS] = '{BTN_LEFT, BTN_MIDDLE, BTN_RIGHT};
    localparam int FLAG_WHEEL = 10;

    // Fixed event slots: move, then down/up per button, then wheel.
    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int SLOT_MOVE  = 0;
    localparam int SLOT_WHEEL = NUM_SLOTS - 1;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [HELD_W-1:0] held;
    } t_dev_state;

    typedef struct packed {
        logic [POS_W-1:0] x_min;
        logic [POS_W-1:0] x_max;
        logic [POS_W-1:0] y_min;
        logic [POS_W-1:0] y_max;
    } t_clip;

    typedef struct packed {
        logic [DEV_W-1:0]                  dev;
        logic [POS_W-1:0]                  pos_x;
        logic [POS_W-1:0]                  pos_y;
        logic signed [MOT_W-1:0]           move_dx;
        logic signed [MOT_W-1:0]           move_dy;
        logic signed [MOT_W-1:0]           wheel;
        logic [MOD_W-1:0]                  mods;
        logic [TOG_W-1:0]                  tog;
        logic [NUM_SLOTS-1:0][ACT_W-1:0]   act;
        logic [NUM_SLOTS-1:0][BTN_W-1:0]   btn;
        logic [NUM_SLOTS-1:0][HELD_W-1:0]  held;
        logic [NUM_SLOTS-1:0]              mask;
    } t_evt_set;

    typedef struct packed {
        logic buf_free;
        logic pending;
    } t_emit_status;

endpackage

`default_nettype wire

/* hw/rtl/mouse_report_event_generator.sv */
// Top level of the mouse report event generator.
//
// Each transfer on the slave stream is one mouse report; it yields zero to
// eight pointer events on the master stream, in the order move or drag,
// left, middle and right press/release, wheel. tlast marks the final event
// of each report, and a report that causes no event produces no transfer.
// The clip rectangle is written through the always-ready configuration channel;
// the user must write it only while the block is idle (the block does not enforce it).
// A report passes through the input register and the event buffer to the output
// register. Events leave at one per cycle while the receiver is ready; the serial
// event buffer sends each report's events one after another.
// A new report is taken while the previous one's last event is being sent,
// and the input register holds a further report while the buffer drains.
// When the receiver stalls, the output register holds its event and the
// slave side stops taking reports once the input register is full.
// Reset clears all positions and held masks to zero (through valid bits on
// the device store), empties both streams and loads the default rectangle.
`default_nettype none

module mouse_report_event_generator #(
    parameter int NUM_DEVICES = mreg_pkg::DEFAULT_NUM_DEVICES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Slave stream: one report per transfer.
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // move_x[15:0], move_y[31:16], button_flags[47:32], wheel_amount[63:48],
    // modifier_keys[67:64], toggle_keys[70:68], zero [71]
    input  wire logic [mreg_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // device_index[1:0]
    input  wire logic [mreg_pkg::DEV_W-1:0]        i_s_tuser,
    // Master stream: one event per transfer.
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // pos_x[14:0], pos_y[29:15], delta_x[45:30], delta_y[61:46], button[63:62],
    // held_buttons[66:64], event_modifiers[70:67], event_toggles[73:71], zero [79:74]
    output logic [mreg_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // last_event
    output logic                                   o_m_tlast,
    // event_device[1:0], action[4:2]
    output logic [mreg_pkg::OUT_TUSER_W-1:0]       o_m_tuser,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mreg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mreg_pkg::POS_W-1:0]        i_cfg_data
);
    import mreg_pkg::*;

    t_clip                  r_clip;
    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_data;
    logic [DEV_W-1:0]       r_in_dev;

    logic                   s_accept;
    logic                   in_commit;
    logic                   dev_ok;
    t_dev_state             cur_state;
    t_dev_state             next_state;
    t_evt_set               evt_set;
    t_emit_status           emit_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.x_min <= X_MIN_RESET;
            r_clip.x_max <= X_MAX_RESET;
            r_clip.y_min <= Y_MIN_RESET;
            r_clip.y_max <= Y_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_X_MIN: r_clip.x_min <= i_cfg_data;
                CFG_X_MAX: r_clip.x_max <= i_cfg_data;
                CFG_Y_MIN: r_clip.y_min <= i_cfg_data;
                CFG_Y_MAX: r_clip.y_max <= i_cfg_data;
                default:   r_clip       <= r_clip;
            endcase
        end
    end

    // The report in the input register moves on once the event buffer is free.
    assign in_commit  = r_in_valid && emit_status.buf_free;
    assign o_s_tready = !r_in_valid || in_commit;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign dev_ok     = int'(r_in_dev) < NUM_DEVICES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_data <= i_s_tdata;
            r_in_dev  <= i_s_tuser;
        end
    end

    mreg_state #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_dev  (i_s_tuser),
        .i_wr_en   (in_commit && dev_ok),
        .i_wr_dev  (r_in_dev),
        .i_wr_data (next_state),
        .o_rd_data (cur_state)
    );

    mreg_build u_build (
        .i_dev    (r_in_dev),
        .i_dev_ok (dev_ok),
        .i_move_x ($signed(r_in_data[15:0])),
        .i_move_y ($signed(r_in_data[31:16])),
        .i_flags  (r_in_data[47:32]),
        .i_wheel  ($signed(r_in_data[63:48])),
        .i_mods   (r_in_data[67:64]),
        .i_tog    (r_in_data[70:68]),
        .i_state  (cur_state),
        .i_clip   (r_clip),
        .o_set    (evt_set),
        .o_next   (next_state)
    );

    mreg_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_commit),
        .i_set      (evt_set),
        .o_status   (emit_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    logic [ACT_W-1:0] out_act;
    logic [BTN_W-1:0] out_btn;

    assign out_act = o_m_tuser[4:2];
    assign out_btn = o_m_tdata[63:62];

    // A report waiting for the buffer must not change underneath.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !in_commit |=> r_in_valid && $stable(r_in_data) && $stable(r_in_dev))
        else $error("input register changed while waiting for the event buffer");

    // An event that is not the last of its report leaves further events behind.
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |-> emit_status.pending)
        else $error("non-final event sent with no events pending");

    // Button events name a button; the others do not.
    a_btn_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (((out_act == ACT_PRESS) || (out_act == ACT_RELEASE))
                        == (out_btn != BTN_NONE)))
        else $error("button field does not match the action");

endmodule

`default_nettype wire

/* hw/rtl/mreg_state.sv */
// Per-device position and held-button store with a registered, bypassed read.
`default_nettype none

module mreg_state #(
    parameter int NUM_DEVICES = mreg_pkg::DEFAULT_NUM_DEVICES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [mreg_pkg::DEV_W-1:0]  i_rd_dev,
    input  wire logic                        i_wr_en,
    input  wire logic [mreg_pkg::DEV_W-1:0]  i_wr_dev,
    input  wire mreg_pkg::t_dev_state        i_wr_data,
    output mreg_pkg::t_dev_state             o_rd_data
);
    import mreg_pkg::*;

    localparam int ADDR_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    t_dev_state                   r_mem [NUM_DEVICES];
    logic [NUM_DEVICES-1:0]       r_valid;
    t_dev_state                   r_rd;
    logic [ADDR_W+DEV_W-1:0]      rd_wide;
    logic [ADDR_W+DEV_W-1:0]      wr_wide;
    logic [ADDR_W-1:0]            raddr;
    logic [ADDR_W-1:0]            waddr;
    logic                         rd_ok;

    assign rd_wide = {{ADDR_W{1'b0}}, i_rd_dev};
    assign wr_wide = {{ADDR_W{1'b0}}, i_wr_dev};
    assign raddr   = rd_wide[ADDR_W-1:0];
    assign waddr   = wr_wide[ADDR_W-1:0];
    assign rd_ok   = int'(i_rd_dev) < NUM_DEVICES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[waddr] <= i_wr_data;
        end
    end

    // A write in the same cycle is forwarded so that back-to-back reports
    // from one device see the latest state. Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_dev == i_rd_dev)) begin
                r_rd <= i_wr_data;
            end else if (rd_ok && r_valid[raddr]) begin
                r_rd <= r_mem[raddr];
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

/* hw/rtl/mreg_build.sv */
// Clips the motion of one report and builds its set of candidate events.
`default_nettype none

module mreg_build (
    input  wire logic [mreg_pkg::DEV_W-1:0]         i_dev,
    input  wire logic                               i_dev_ok,
    input  wire logic signed [mreg_pkg::MOT_W-1:0]  i_move_x,
    input  wire logic signed [mreg_pkg::MOT_W-1:0]  i_move_y,
    input  wire logic [mreg_pkg::FLAG_W-1:0]        i_flags,
    input  wire logic signed [mreg_pkg::MOT_W-1:0]  i_wheel,
    input  wire logic [mreg_pkg::MOD_W-1:0]         i_mods,
    input  wire logic [mreg_pkg::TOG_W-1:0]         i_tog,
    input  wire mreg_pkg::t_dev_state               i_state,
    input  wire mreg_pkg::t_clip                    i_clip,
    output mreg_pkg::t_evt_set                      o_set,
    output mreg_pkg::t_dev_state                    o_next
);
    import mreg_pkg::*;

    // Lower bound first, then upper bound, then saturate at zero.
    function automatic logic [POS_W-1:0] clip_axis(
        input logic [POS_W-1:0]        pos,
        input logic signed [MOT_W-1:0] d,
        input logic [POS_W-1:0]        lo,
        input logic [POS_W-1:0]        hi
    );
        logic signed [POS_W+2:0] n;
        logic signed [POS_W+2:0] lo_s;
        logic signed [POS_W+2:0] hi_s;
        lo_s = $signed({3'b000, lo});
        hi_s = $signed({3'b000, hi});
        n = $signed({3'b000, pos}) + (POS_W+3)'(d);
        if (n < lo_s) n = lo_s;
        if (n >= hi_s) n = hi_s - 18'sd1;
        if (n < 18'sd0) n = 18'sd0;
        return n[POS_W-1:0];
    endfunction

    logic [POS_W-1:0]        nx;
    logic [POS_W-1:0]        ny;
    logic signed [MOT_W-1:0] dx;
    logic signed [MOT_W-1:0] dy;
    logic [HELD_W-1:0]       held_v;
    t_evt_set                set;

    assign nx = clip_axis(i_state.pos_x, i_move_x, i_clip.x_min, i_clip.x_max);
    assign ny = clip_axis(i_state.pos_y, i_move_y, i_clip.y_min, i_clip.y_max);
    assign dx = $signed({1'b0, nx}) - $signed({1'b0, i_state.pos_x});
    assign dy = $signed({1'b0, ny}) - $signed({1'b0, i_state.pos_y});

    always_comb begin
        held_v      = i_state.held;
        set         = '0;
        set.dev     = i_dev;
        set.pos_x   = nx;
        set.pos_y   = ny;
        set.move_dx = dx;
        set.move_dy = dy;
        set.wheel   = i_wheel;
        set.mods    = i_mods;
        set.tog     = i_tog;

        set.mask[SLOT_MOVE] = (dx != '0) || (dy != '0);
        set.act[SLOT_MOVE]  = (held_v != '0) ? ACT_DRAG : ACT_MOVE;
        set.btn[SLOT_MOVE]  = BTN_NONE;
        set.held[SLOT_MOVE] = held_v;

        // A press shows the mask before the button is added, a release after
        // it is removed.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            set.mask[1+2*b] = i_flags[DOWN_BIT[b]];
            set.act[1+2*b]  = ACT_PRESS;
            set.btn[1+2*b]  = BTN_OF[b];
            set.held[1+2*b] = held_v;
            if (i_flags[DOWN_BIT[b]]) held_v[b] = 1'b1;
            if (i_flags[UP_BIT[b]]) held_v[b] = 1'b0;
            set.mask[2+2*b] = i_flags[UP_BIT[b]];
            set.act[2+2*b]  = ACT_RELEASE;
            set.btn[2+2*b]  = BTN_OF[b];
            set.held[2+2*b] = held_v;
        end

        set.mask[SLOT_WHEEL] = i_flags[FLAG_WHEEL];
        set.act[SLOT_WHEEL]  = ACT_WHEEL;
        set.btn[SLOT_WHEEL]  = BTN_NONE;
        set.held[SLOT_WHEEL] = held_v;

        if (!i_dev_ok) begin
            set.mask = '0;
        end
    end

    assign o_set  = set;
    assign o_next = '{pos_x: nx, pos_y: ny, held: held_v};

endmodule

`default_nettype wire

/* hw/rtl/mreg_emit.sv */
// Event buffer that sends the pending events of one report through the output register.
`default_nettype none

module mreg_emit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire mreg_pkg::t_evt_set                i_set,
    output mreg_pkg::t_emit_status                 o_status,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [mreg_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                   o_m_tlast,
    output logic [mreg_pkg::OUT_TUSER_W-1:0]       o_m_tuser
);
    import mreg_pkg::*;

    t_evt_set                 r_set;
    logic [NUM_SLOTS-1:0]     r_mask;
    logic                     r_m_tvalid;
    logic [OUT_TDATA_W-1:0]   r_m_tdata;
    logic                     r_m_tlast;
    logic [OUT_TUSER_W-1:0]   r_m_tuser;

    logic [NUM_SLOTS-1:0]     pick;
    logic [NUM_SLOTS-1:0]     remain;
    logic [SLOT_IDX_W-1:0]    idx;
    logic                     out_load;
    logic signed [MOT_W-1:0]  dx;
    logic signed [MOT_W-1:0]  dy;

    // The lowest pending slot goes next, which keeps the event order.
    always_comb begin
        pick = r_mask & (~r_mask + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
        idx  = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (pick[s]) idx = SLOT_IDX_W'(s);
        end
        remain = r_mask & ~pick;
    end

    always_comb begin
        dx = '0;
        dy = '0;
        if (idx == SLOT_IDX_W'(SLOT_MOVE)) begin
            dx = r_set.move_dx;
            dy = r_set.move_dy;
        end else if (idx == SLOT_IDX_W'(SLOT_WHEEL)) begin
            dx = r_set.wheel;
        end
    end

    assign out_load = (r_mask != '0) && (!r_m_tvalid || i_m_tready);

    assign o_status.pending  = r_mask != '0;
    assign o_status.buf_free = (r_mask == '0) || ((remain == '0) && out_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_set.mask;
        end else if (out_load) begin
            r_mask <= remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_set <= i_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_tdata <= {6'b000000, r_set.tog, r_set.mods, r_set.held[idx], r_set.btn[idx],
                          dy, dx, r_set.pos_y, r_set.pos_x};
            r_m_tuser <= {r_set.act[idx], r_set.dev};
            r_m_tlast <= remain == '0;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;
    assign o_m_tuser  = r_m_tuser;

endmodule

`default_nettype wire
